FILE: hw/rtl/arss_pkg.sv
// Shared types, field widths, codes and register reset values of the shunt range selector.
package arss_pkg;

    // Defaults of the top-level parameters.
    localparam int NUM_RANGES_DEF  = 6;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths of the ports.
    localparam int SAMPLE_W  = 16;
    localparam int SPAN_W    = 16;
    localparam int RANGE_W   = 3;
    localparam int RATIO_W   = 16;
    localparam int DIR_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Action codes carried by an input beat.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_LOAD   = 1'b1;

    // Direction codes of a result beat.
    localparam logic [DIR_W-1:0] DIR_HELD = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_RATIO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RATIO  = 2'd2;

    // Register reset values (0.15 and 0.85 in Q0.16).
    localparam logic               AUTO_ENABLE_RST = 1'b1;
    localparam logic [RATIO_W-1:0] LOW_RATIO_RST   = 16'd9830;
    localparam logic [RATIO_W-1:0] HIGH_RATIO_RST  = 16'd55706;

    // Per-beat control of one extreme-tracking lane.
    typedef struct packed {
        logic update;
        logic last;
    } lane_ctrl_t;

endpackage

FILE: hw/rtl/arss_lane.sv
// One channel lane: running minimum and maximum of a signed sample stream over a buffer.
module arss_lane #(
    parameter int SAMPLE_BITS = arss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  arss_pkg::lane_ctrl_t          ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] max_next,
    output logic signed [SAMPLE_BITS-1:0] min_next
);
    import arss_pkg::*;

    logic                          have_first_reg;
    logic                          have_first_next;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;

    // The first sample of a buffer seeds both extremes.
    always_comb begin
        if (!have_first_reg) begin
            max_next = sample;
            min_next = sample;
        end else begin
            max_next = (sample > max_reg) ? sample : max_reg;
            min_next = (sample < min_reg) ? sample : min_reg;
        end
        have_first_next = have_first_reg;
        if (ctrl.update) begin
            have_first_next = !ctrl.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg <= 1'b0;
        end else begin
            have_first_reg <= have_first_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.update) begin
            max_reg <= max_next;
            min_reg <= min_next;
        end
    end

endmodule

FILE: hw/rtl/arss_merge.sv
// Merging pipeline: spans, ratio products, range decision and the result register.
module arss_merge #(
    parameter int NUM_RANGES  = arss_pkg::NUM_RANGES_DEF,
    parameter int SAMPLE_BITS = arss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_load,
    input  logic [arss_pkg::RANGE_W-1:0]          in_range,
    input  logic signed [SAMPLE_BITS-1:0]         in_max_a,
    input  logic signed [SAMPLE_BITS-1:0]         in_min_a,
    input  logic signed [SAMPLE_BITS-1:0]         in_max_b,
    input  logic signed [SAMPLE_BITS-1:0]         in_min_b,
    input  logic                                  auto_enable,
    input  logic [arss_pkg::RATIO_W-1:0]          low_ratio,
    input  logic [arss_pkg::RATIO_W-1:0]          high_ratio,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [arss_pkg::RANGE_W-1:0]          out_range,
    output logic [arss_pkg::DIR_W-1:0]            out_dir,
    output logic [arss_pkg::SPAN_W-1:0]           out_larger,
    output logic [arss_pkg::SPAN_W-1:0]           out_smaller
);
    import arss_pkg::*;

    localparam int                 PROD_W    = SAMPLE_BITS + RATIO_W;
    localparam logic [RANGE_W-1:0] RANGE_MAX = RANGE_W'(NUM_RANGES - 1);

    // Stage A: captured extremes.
    logic                          a_valid_reg;
    logic                          a_load_reg;
    logic [RANGE_W-1:0]            a_range_reg;
    logic signed [SAMPLE_BITS-1:0] a_max_a_reg, a_min_a_reg, a_max_b_reg, a_min_b_reg;
    // Stage B: spans of both channels.
    logic                          b_valid_reg;
    logic                          b_load_reg;
    logic [RANGE_W-1:0]            b_range_reg;
    logic [SAMPLE_BITS-1:0]        b_span_a_reg, b_span_b_reg;
    // Stage C: larger and smaller span.
    logic                          c_valid_reg;
    logic                          c_load_reg;
    logic [RANGE_W-1:0]            c_range_reg;
    logic [SAMPLE_BITS-1:0]        c_larger_reg, c_smaller_reg;
    // Stage D: ratio products.
    logic                          d_valid_reg;
    logic                          d_load_reg;
    logic [RANGE_W-1:0]            d_range_reg;
    logic [SAMPLE_BITS-1:0]        d_larger_reg, d_smaller_reg;
    logic [PROD_W-1:0]             d_prod_lo_reg, d_prod_hi_reg;
    // Result stage.
    logic                          out_valid_reg;
    logic [RANGE_W-1:0]            range_reg;
    logic [RANGE_W-1:0]            range_next;
    logic [DIR_W-1:0]              dir_reg, dir_next;
    logic [SPAN_W-1:0]             larger_reg, smaller_reg;
    logic [SPAN_W-1:0]             larger_next, smaller_next;

    logic                          out_free, d_free, c_free, b_free, a_free;
    logic [SAMPLE_BITS:0]          diff_a, diff_b;
    logic [PROD_W-1:0]             scaled;
    logic                          step_up, step_down;
    logic [RANGE_W-1:0]            idx_up;

    // A stage takes a new beat when it is empty or its contents move on.
    assign out_free = !out_valid_reg || out_ready;
    assign d_free   = !d_valid_reg || out_free;
    assign c_free   = !c_valid_reg || d_free;
    assign b_free   = !b_valid_reg || c_free;
    assign a_free   = !a_valid_reg || b_free;
    assign in_ready = a_free;

    assign diff_a = (SAMPLE_BITS + 1)'(a_max_a_reg) - (SAMPLE_BITS + 1)'(a_min_a_reg);
    assign diff_b = (SAMPLE_BITS + 1)'(a_max_b_reg) - (SAMPLE_BITS + 1)'(a_min_b_reg);

    assign scaled = {d_smaller_reg, {RATIO_W{1'b0}}};

    // Step up is applied before step down; both only in auto mode.
    always_comb begin
        step_up   = auto_enable && (d_prod_lo_reg > scaled);
        step_down = auto_enable && (d_prod_hi_reg < scaled);
        idx_up    = (step_up && (range_reg < RANGE_MAX)) ? range_reg + 1'b1 : range_reg;
        if (d_load_reg) begin
            range_next   = d_range_reg;
            dir_next     = DIR_HELD;
            larger_next  = '0;
            smaller_next = '0;
        end else begin
            range_next   = (step_down && (idx_up != '0)) ? idx_up - 1'b1 : idx_up;
            if (range_next > range_reg) begin
                dir_next = DIR_UP;
            end else if (range_next < range_reg) begin
                dir_next = DIR_DOWN;
            end else begin
                dir_next = DIR_HELD;
            end
            larger_next  = SPAN_W'(d_larger_reg);
            smaller_next = SPAN_W'(d_smaller_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            range_reg     <= '0;
        end else begin
            if (a_free) begin
                a_valid_reg <= in_valid;
            end
            if (b_free) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_free) begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_free) begin
                d_valid_reg <= c_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= d_valid_reg;
                if (d_valid_reg) begin
                    range_reg <= range_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_free) begin
            a_load_reg  <= in_load;
            a_range_reg <= in_range;
            a_max_a_reg <= in_max_a;
            a_min_a_reg <= in_min_a;
            a_max_b_reg <= in_max_b;
            a_min_b_reg <= in_min_b;
        end
        if (b_free) begin
            b_load_reg   <= a_load_reg;
            b_range_reg  <= a_range_reg;
            b_span_a_reg <= diff_a[SAMPLE_BITS-1:0];
            b_span_b_reg <= diff_b[SAMPLE_BITS-1:0];
        end
        if (c_free) begin
            c_load_reg    <= b_load_reg;
            c_range_reg   <= b_range_reg;
            c_larger_reg  <= (b_span_a_reg > b_span_b_reg) ? b_span_a_reg : b_span_b_reg;
            c_smaller_reg <= (b_span_a_reg < b_span_b_reg) ? b_span_a_reg : b_span_b_reg;
        end
        if (d_free) begin
            d_load_reg    <= c_load_reg;
            d_range_reg   <= c_range_reg;
            d_larger_reg  <= c_larger_reg;
            d_smaller_reg <= c_smaller_reg;
            d_prod_lo_reg <= PROD_W'(c_larger_reg) * PROD_W'(low_ratio);
            d_prod_hi_reg <= PROD_W'(c_larger_reg) * PROD_W'(high_ratio);
        end
        if (out_free && d_valid_reg) begin
            dir_reg     <= dir_next;
            larger_reg  <= larger_next;
            smaller_reg <= smaller_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_range   = range_reg;
    assign out_dir     = dir_reg;
    assign out_larger  = larger_reg;
    assign out_smaller = smaller_reg;

endmodule

FILE: hw/rtl/auto_range_shunt_selector_core.sv
// Top level of the auto-ranging shunt selector: lanes, merging pipeline and register file.
//
//  Channel   Direction  Beat carries                                   Handshake
//  s_        in         action, sample_a, sample_b, last_sample,       s_valid / s_ready
//                       range_value
//  m_        out        range_index, direction, span_larger,           m_valid / m_ready
//                       span_smaller
//  cfg_      in         register index, write data                     cfg_valid / cfg_ready
//
// One input beat is taken every clock unless the merging pipeline is full and stalled.
// A result follows the beat that causes it (a last sample pair or a load) through the
// capture, span, select, multiply and decide stages of the merging pipeline.
// Reset (aresetn, synchronous, active low) clears the range index to the smallest
// shunt, empties the pipeline and restores the register defaults.
// When a result waits on m_ready, beats keep being taken until the merging pipeline
// holds five pending results; non-final sample pairs only update the lanes.
module auto_range_shunt_selector_core #(
    parameter int NUM_RANGES  = arss_pkg::NUM_RANGES_DEF,
    parameter int SAMPLE_BITS = arss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_action,
    input  logic signed [arss_pkg::SAMPLE_W-1:0]  s_sample_a,
    input  logic signed [arss_pkg::SAMPLE_W-1:0]  s_sample_b,
    input  logic                                  s_last_sample,
    input  logic [arss_pkg::RANGE_W-1:0]          s_range_value,
    // Result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [arss_pkg::RANGE_W-1:0]          m_range_index,
    output logic [arss_pkg::DIR_W-1:0]            m_direction,
    output logic [arss_pkg::SPAN_W-1:0]           m_span_larger,
    output logic [arss_pkg::SPAN_W-1:0]           m_span_smaller,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [arss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [arss_pkg::CFG_DAT_W-1:0]        cfg_data
);
    import arss_pkg::*;

    localparam logic [RANGE_W-1:0] RANGE_MAX = RANGE_W'(NUM_RANGES - 1);

    logic                          auto_enable_reg;
    logic [RATIO_W-1:0]            low_ratio_reg;
    logic [RATIO_W-1:0]            high_ratio_reg;

    logic                          s_accept;
    lane_ctrl_t                    lane_ctrl;
    logic signed [SAMPLE_BITS-1:0] sample_a, sample_b;
    logic signed [SAMPLE_BITS-1:0] max_a, min_a, max_b, min_b;
    logic                          token_valid;
    logic [RANGE_W-1:0]            load_range;

    // Register writes are always taken; an index past the list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_enable_reg <= AUTO_ENABLE_RST;
            low_ratio_reg   <= LOW_RATIO_RST;
            high_ratio_reg  <= HIGH_RATIO_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_AUTO_ENABLE: auto_enable_reg <= cfg_data[0];
                CFG_LOW_RATIO:   low_ratio_reg   <= cfg_data[RATIO_W-1:0];
                CFG_HIGH_RATIO:  high_ratio_reg  <= cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // Samples are read as SAMPLE_BITS-bit two's complement from the low bits of
    // their fields; bits above the field read as zero.
    assign sample_a = SAMPLE_BITS'($unsigned(s_sample_a));
    assign sample_b = SAMPLE_BITS'($unsigned(s_sample_b));

    assign s_accept         = s_valid && s_ready;
    assign lane_ctrl.update = s_accept && (s_action == ACT_SAMPLE);
    assign lane_ctrl.last   = s_last_sample;

    arss_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (lane_ctrl),
        .sample   (sample_a),
        .max_next (max_a),
        .min_next (min_a)
    );

    arss_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (lane_ctrl),
        .sample   (sample_b),
        .max_next (max_b),
        .min_next (min_b)
    );

    // Only a load or the last pair of a buffer sends a beat into the merging
    // pipeline; the extremes passed on already include that last pair.
    assign token_valid = s_valid && ((s_action == ACT_LOAD) || s_last_sample);

    // A loaded index beyond the top range saturates to the top range.
    assign load_range = (s_range_value > RANGE_MAX) ? RANGE_MAX : s_range_value;

    arss_merge #(
        .NUM_RANGES  (NUM_RANGES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (token_valid),
        .in_ready    (s_ready),
        .in_load     (s_action == ACT_LOAD),
        .in_range    (load_range),
        .in_max_a    (max_a),
        .in_min_a    (min_a),
        .in_max_b    (max_b),
        .in_min_b    (min_b),
        .auto_enable (auto_enable_reg),
        .low_ratio   (low_ratio_reg),
        .high_ratio  (high_ratio_reg),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_range   (m_range_index),
        .out_dir     (m_direction),
        .out_larger  (m_span_larger),
        .out_smaller (m_span_smaller)
    );

`ifndef SYNTH
    // The range index never leaves the configured set of shunts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_range_index <= RANGE_MAX))
        else $error("range index above top range");

    // With auto mode off the index can only change through a load, which reports held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !auto_enable_reg) |-> (m_direction == DIR_HELD))
        else $error("range moved with auto mode off");

    // A step up never lands on the smallest shunt.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_direction == DIR_UP)) |-> (m_range_index != '0))
        else $error("step up reported at range zero");

    // A step down never lands on the top range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_direction == DIR_DOWN)) |-> (m_range_index != RANGE_MAX))
        else $error("step down reported at top range");
`endif

endmodule

FILE: dv/tb_auto_range_shunt_selector_core.sv
// Self-checking testbench of the auto-ranging shunt selector core.
module tb_auto_range_shunt_selector_core;
    import arss_pkg::*;

    // Run control. The limit is far above the slowest correct run: about 1700 beats,
    // at most one result each, with both sides idling and a few register writes.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_PERCENT  = 8;
    localparam int QUIET_FROM    = 800;
    localparam int QUIET_TO      = 1500;
    localparam int REPORT_LIMIT  = 10;
    localparam int TOP_RANGE     = NUM_RANGES_DEF - 1;

    // Index 3 selects no register; a write to it must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    // One input beat as the driver presents it.
    typedef struct {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample_a;
        logic signed [SAMPLE_W-1:0] sample_b;
        logic                       last_sample;
        logic [RANGE_W-1:0]         range_value;
    } pair_beat_t;

    // One range decision as the result channel carries it.
    typedef struct packed {
        logic [RANGE_W-1:0] range_index;
        logic [DIR_W-1:0]   direction;
        logic [SPAN_W-1:0]  span_larger;
        logic [SPAN_W-1:0]  span_smaller;
    } decision_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic                 s_action       = ACT_SAMPLE;
    logic signed [SAMPLE_W-1:0] s_sample_a = '0;
    logic signed [SAMPLE_W-1:0] s_sample_b = '0;
    logic                 s_last_sample  = 1'b0;
    logic [RANGE_W-1:0]   s_range_value  = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [RANGE_W-1:0]   m_range_index;
    logic [DIR_W-1:0]     m_direction;
    logic [SPAN_W-1:0]    m_span_larger;
    logic [SPAN_W-1:0]    m_span_smaller;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CFG_DAT_W-1:0] cfg_data       = '0;

    // Beats waiting to be driven, and decisions waiting to come out of the block.
    pair_beat_t pending_pairs_q[$];
    decision_t  decision_q[$];

    // Set at the rising edge that takes a beat, so that the driver moves on to the
    // next one at the following falling edge.
    bit beat_taken    = 1'b0;
    int cycle_count   = 0;
    int mismatch_count = 0;

    // Our own copy of the register settings, starting from their reset values.
    logic               cf_auto = AUTO_ENABLE_RST;
    logic [RATIO_W-1:0] cf_low  = LOW_RATIO_RST;
    logic [RATIO_W-1:0] cf_high = HIGH_RATIO_RST;

    // Our own copy of the tracking state: whether the current buffer has its first
    // pair, the running extremes of both channels, and the range index.
    bit                         buf_open = 1'b0;
    logic signed [SAMPLE_W-1:0] peak_hi_a = '0;
    logic signed [SAMPLE_W-1:0] peak_lo_a = '0;
    logic signed [SAMPLE_W-1:0] peak_hi_b = '0;
    logic signed [SAMPLE_W-1:0] peak_lo_b = '0;
    logic [RANGE_W-1:0]         shunt_range = '0;

    auto_range_shunt_selector_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_sample_a    (s_sample_a),
        .s_sample_b    (s_sample_b),
        .s_last_sample (s_last_sample),
        .s_range_value (s_range_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_range_index (m_range_index),
        .m_direction   (m_direction),
        .m_span_larger (m_span_larger),
        .m_span_smaller(m_span_smaller),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // The clock has a period of 20 time units.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Both sides hold off at random about 8 percent of the time, except in one long window
    // where the block runs at full rate in both directions.
    function automatic bit take_idle();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    // Counts a failure and reports the first few of them in full.
    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0d: %s", cycle_count, msg);
        end
    endtask

    task automatic push_beat(input logic action, input logic [SAMPLE_W-1:0] a,
                             input logic [SAMPLE_W-1:0] b, input logic last,
                             input logic [RANGE_W-1:0] rv);
        pair_beat_t beat;
        beat.action      = action;
        beat.sample_a    = a;
        beat.sample_b    = b;
        beat.last_sample = last;
        beat.range_value = rv;
        pending_pairs_q.push_back(beat);
    endtask

    // Works out what one accepted beat does to the range state. A load and the last
    // pair of a buffer each yield one decision; any other pair only widens the
    // running extremes.
    task automatic apply_beat(input pair_beat_t beat);
        int                 span_a;
        int                 span_b;
        int                 larger;
        int                 smaller;
        longint unsigned    scaled;
        bit                 go_up;
        bit                 go_down;
        logic [RANGE_W-1:0] prior;
        logic [RANGE_W-1:0] stepped;
        decision_t          d;
        if (beat.action == ACT_LOAD) begin
            // A load saturates at the top range and leaves the extremes untouched.
            stepped = (beat.range_value > TOP_RANGE) ? RANGE_W'(TOP_RANGE) : beat.range_value;
            shunt_range    = stepped;
            d.range_index  = stepped;
            d.direction    = DIR_HELD;
            d.span_larger  = '0;
            d.span_smaller = '0;
            decision_q.push_back(d);
            return;
        end
        // The first pair of a buffer seeds both extremes of each channel.
        if (!buf_open) begin
            peak_hi_a = beat.sample_a;
            peak_lo_a = beat.sample_a;
            peak_hi_b = beat.sample_b;
            peak_lo_b = beat.sample_b;
            buf_open  = 1'b1;
        end else begin
            if (beat.sample_a > peak_hi_a) peak_hi_a = beat.sample_a;
            if (beat.sample_a < peak_lo_a) peak_lo_a = beat.sample_a;
            if (beat.sample_b > peak_hi_b) peak_hi_b = beat.sample_b;
            if (beat.sample_b < peak_lo_b) peak_lo_b = beat.sample_b;
        end
        if (!beat.last_sample) begin
            return;
        end
        buf_open = 1'b0;
        span_a   = int'(peak_hi_a) - int'(peak_lo_a);
        span_b   = int'(peak_hi_b) - int'(peak_lo_b);
        larger   = (span_a > span_b) ? span_a : span_b;
        smaller  = (span_a < span_b) ? span_a : span_b;
        // The ratio tests are exact: the smaller span is scaled by 2^16 instead of
        // the ratio being turned into a fraction.
        scaled   = longint'(smaller) << 16;
        go_up    = (longint'(larger) * longint'(cf_low)) > scaled;
        go_down  = (longint'(larger) * longint'(cf_high)) < scaled;
        prior    = shunt_range;
        stepped  = shunt_range;
        if (cf_auto) begin
            // With both tests true the step up comes first, then the step down.
            if (go_up && stepped < TOP_RANGE) stepped = stepped + 1'b1;
            if (go_down && stepped > 0) stepped = stepped - 1'b1;
        end
        shunt_range    = stepped;
        d.range_index  = stepped;
        d.direction    = (stepped > prior) ? DIR_UP : (stepped < prior) ? DIR_DOWN : DIR_HELD;
        d.span_larger  = SPAN_W'(larger);
        d.span_smaller = SPAN_W'(smaller);
        decision_q.push_back(d);
    endtask

    // Compares one result beat, field by field, with the oldest pending decision.
    task automatic check_decision();
        decision_t got;
        decision_t want;
        got.range_index  = m_range_index;
        got.direction    = m_direction;
        got.span_larger  = m_span_larger;
        got.span_smaller = m_span_smaller;
        if (decision_q.size() == 0) begin
            flag_error($sformatf("unexpected result: range %0d dir %0d larger %0d smaller %0d",
                                 got.range_index, got.direction, got.span_larger,
                                 got.span_smaller));
            return;
        end
        want = decision_q.pop_front();
        if (got.range_index !== want.range_index || got.direction !== want.direction ||
            got.span_larger !== want.span_larger || got.span_smaller !== want.span_smaller) begin
            flag_error($sformatf({"mismatch: expected range %0d dir %0d larger %0d smaller %0d,",
                                  " got range %0d dir %0d larger %0d smaller %0d"},
                                 want.range_index, want.direction, want.span_larger,
                                 want.span_smaller, got.range_index, got.direction,
                                 got.span_larger, got.span_smaller));
        end
    endtask

    // The driver changes the input beat at the falling edge. A beat that is on the
    // port stays there, unchanged, until the rising edge that takes it; only then
    // may the driver idle or present the next one.
    always @(negedge aclk) begin
        if (!s_valid || beat_taken) begin
            if (aresetn && pending_pairs_q.size() > 0 && !take_idle()) begin
                s_valid       <= 1'b1;
                s_action      <= pending_pairs_q[0].action;
                s_sample_a    <= pending_pairs_q[0].sample_a;
                s_sample_b    <= pending_pairs_q[0].sample_b;
                s_last_sample <= pending_pairs_q[0].last_sample;
                s_range_value <= pending_pairs_q[0].range_value;
            end else begin
                s_valid <= 1'b0;
            end
        end
        beat_taken = 1'b0;
    end

    // The receiver stalls the result channel at random, also at the falling edge.
    always @(negedge aclk) begin
        m_ready <= !take_idle();
    end

    // The monitor samples both channels at the rising edge. An accepted input beat is
    // run through the predictor at once, so the decisions queue up in the order the
    // block must deliver them.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                apply_beat(pending_pairs_q.pop_front());
                beat_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                check_decision();
            end
        end
    end

    // Writes one register through the configuration channel and mirrors it.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_AUTO_ENABLE: cf_auto = data[0];
            CFG_LOW_RATIO:   cf_low  = data;
            CFG_HIGH_RATIO:  cf_high = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every beat is taken and every decision has come out, then gives a
    // trailing pair with no result time to leave the pipeline.
    task automatic drain();
        while (pending_pairs_q.size() > 0 || decision_q.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Queues random traffic. Most of it is whole buffers whose two channels get
    // spans of independently random sizes, so that the range steps both ways and holds.
    // Loads are spread between and inside buffers, and a stray last flag now and
    // then cuts a buffer short.
    task automatic queue_random(input int count);
        int                  pushed;
        int                  len;
        logic [31:0]         mask_a;
        logic [31:0]         mask_b;
        logic [SAMPLE_W-1:0] center_a;
        logic [SAMPLE_W-1:0] center_b;
        pushed = 0;
        while (pushed < count) begin
            if ($urandom_range(0, 99) < 8) begin
                push_beat(ACT_LOAD, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                          1'($urandom_range(0, 1)), RANGE_W'($urandom_range(0, 7)));
                pushed++;
            end else begin
                len      = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 24)
                                                       : $urandom_range(1, 6);
                mask_a   = (32'd1 << $urandom_range(0, 16)) - 1;
                mask_b   = (32'd1 << $urandom_range(0, 16)) - 1;
                center_a = SAMPLE_W'($urandom);
                center_b = SAMPLE_W'($urandom);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 99) < 3) begin
                        push_beat(ACT_LOAD, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b0,
                                  RANGE_W'($urandom_range(0, 7)));
                    end
                    push_beat(ACT_SAMPLE, SAMPLE_W'(center_a + ($urandom & mask_a)),
                              SAMPLE_W'(center_b + ($urandom & mask_b)),
                              (k == len - 1) || ($urandom_range(0, 99) < 3),
                              RANGE_W'($urandom_range(0, 7)));
                end
                pushed += len;
            end
        end
    endtask

    // Ends the run if the block stops making progress.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("tb_auto_range_shunt_selector_core: errors");
        $finish;
    end

    initial begin
        // Reset is held from the start of the run and released at a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats under the reset settings, starting from the smallest shunt.
        // A buffer of one pair has zero spans and must hold.
        push_beat(ACT_SAMPLE, 16'sd0, 16'sd0, 1'b1, 3'd0);
        // Channel a swings over the whole range while b barely moves: step up.
        push_beat(ACT_SAMPLE, 16'h8000, 16'sd0, 1'b0, 3'd7);
        push_beat(ACT_SAMPLE, 16'h7FFF, 16'sd1, 1'b1, 3'd0);
        // Both channels at full swing: equal spans step down, then hold at zero.
        push_beat(ACT_SAMPLE, 16'h8000, 16'h8000, 1'b0, 3'd0);
        push_beat(ACT_SAMPLE, 16'h7FFF, 16'h7FFF, 1'b1, 3'd0);
        push_beat(ACT_SAMPLE, 16'h8000, 16'h8000, 1'b0, 3'd0);
        push_beat(ACT_SAMPLE, 16'h7FFF, 16'h7FFF, 1'b1, 3'd0);
        // A load beyond the top range saturates; a step up from the top then holds.
        push_beat(ACT_LOAD, 16'hFFFF, 16'hFFFF, 1'b1, 3'd7);
        push_beat(ACT_SAMPLE, 16'sd100, 16'sd0, 1'b0, 3'd0);
        push_beat(ACT_SAMPLE, -16'sd100, 16'sd1, 1'b1, 3'd0);
        push_beat(ACT_LOAD, 16'sd0, 16'sd0, 1'b0, 3'd6);
        push_beat(ACT_LOAD, 16'sd0, 16'sd0, 1'b0, 3'd5);
        push_beat(ACT_LOAD, 16'h7FFF, 16'h8000, 1'b1, 3'd0);
        // A load in the middle of a buffer must not disturb its extremes.
        push_beat(ACT_SAMPLE, 16'sd10, 16'sd10, 1'b0, 3'd0);
        push_beat(ACT_LOAD, 16'h5555, 16'hAAAA, 1'b0, 3'd2);
        push_beat(ACT_SAMPLE, -16'sd10, 16'sd20, 1'b1, 3'd0);
        push_beat(ACT_LOAD, 16'hAAAA, 16'h5555, 1'b1, 3'd3);
        push_beat(ACT_SAMPLE, 16'sd1, -16'sd1, 1'b0, 3'd4);
        push_beat(ACT_SAMPLE, 16'sd5000, -16'sd200, 1'b1, 3'd1);
        drain();

        queue_random(300);
        drain();

        // With auto mode off the spans are still reported but the range moves only by loads.
        write_register(CFG_AUTO_ENABLE, {(CFG_DAT_W-1)'($urandom_range(0, 32767)), 1'b0});
        queue_random(250);
        drain();

        // Low ratio above high ratio: both tests can pass on the same buffer.
        write_register(CFG_AUTO_ENABLE, {(CFG_DAT_W-1)'($urandom_range(0, 32767)), 1'b1});
        write_register(CFG_LOW_RATIO, 16'hFFFF);
        write_register(CFG_HIGH_RATIO, 16'h0000);
        queue_random(250);
        drain();

        // Opposite extremes: the up test never passes and the down test only on equal nonzero spans.
        write_register(CFG_LOW_RATIO, 16'h0000);
        write_register(CFG_HIGH_RATIO, 16'hFFFF);
        write_register(CFG_SPARE_IDX, CFG_DAT_W'($urandom));
        queue_random(200);
        drain();

        // Two random pairs of thresholds.
        repeat (2) begin
            write_register(CFG_LOW_RATIO, CFG_DAT_W'($urandom));
            write_register(CFG_HIGH_RATIO, CFG_DAT_W'($urandom));
            queue_random(250);
            drain();
        end

        // Back to the reset thresholds.
        write_register(CFG_LOW_RATIO, LOW_RATIO_RST);
        write_register(CFG_HIGH_RATIO, HIGH_RATIO_RST);
        queue_random(100);
        drain();

        while (decision_q.size() > 0) begin
            flag_error($sformatf("missing result: range %0d dir %0d larger %0d smaller %0d",
                                 decision_q[0].range_index, decision_q[0].direction,
                                 decision_q[0].span_larger, decision_q[0].span_smaller));
            void'(decision_q.pop_front());
        end

        if (mismatch_count == 0) begin
            $display("tb_auto_range_shunt_selector_core: clean");
        end else begin
            $display("tb_auto_range_shunt_selector_core: errors");
        end
        $finish;
    end

endmodule
